[rtl/core/daacg_pkg.sv]
// Shared widths, defaults and register indexes for the averaged command gate.
`default_nettype none

package daacg_pkg;

  localparam int SAMPLE_W  = 12;  // width of a sample and of an average on the ports
  localparam int TIME_W    = 32;
  localparam int WIN_REG_W = 5;
  localparam int TOL_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam int MAX_WINDOW_DEF = 16;
  localparam int ADC_BITS_DEF   = 12;

  localparam logic [WIN_REG_W-1:0] WINDOW_LEN_RST = WIN_REG_W'(8);
  localparam logic [TIME_W-1:0]    MIN_PERIOD_RST = '0;
  localparam logic [TIME_W-1:0]    MAX_PERIOD_RST = TIME_W'(1000);
  localparam logic [TOL_W-1:0]     CHANGE_TOL_RST = TOL_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LEN = 2'd0,
    CFG_MIN_PERIOD = 2'd1,
    CFG_MAX_PERIOD = 2'd2,
    CFG_CHANGE_TOL = 2'd3
  } cfg_idx_e;

endpackage

`default_nettype wire

[rtl/core/daacg_if.sv]
// Handshake channels: ADC scan words in, command words out.
`default_nettype none

interface daacg_scan_if;
  logic                                valid;
  logic                                ready;
  logic [daacg_pkg::SAMPLE_W-1:0]      sample_x;
  logic [daacg_pkg::SAMPLE_W-1:0]      sample_y;
  logic [daacg_pkg::TIME_W-1:0]        time_now;

  modport source (output valid, output sample_x, output sample_y, output time_now,
                  input ready);
  modport sink   (input valid, input sample_x, input sample_y, input time_now,
                  output ready);
endinterface

interface daacg_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [daacg_pkg::SAMPLE_W-1:0]      avg_x;
  logic [daacg_pkg::SAMPLE_W-1:0]      avg_y;

  modport source (output valid, output avg_x, output avg_y, input ready);
  modport sink   (input valid, input avg_x, input avg_y, output ready);
endinterface

`default_nettype wire

[rtl/core/daacg_div.sv]
// Two-lane restoring divider, one quotient bit per cycle, shared divisor.
`default_nettype none

module daacg_div #(
  parameter int NUM_W = 17,
  parameter int DEN_W = 5
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [1:0][NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0]      den_i,
  output logic                       done_o,
  output logic [1:0][NUM_W-1:0]      quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic                  busy_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DEN_W-1:0]      den_q;
  logic [1:0][NUM_W-1:0] num_q;
  logic [1:0][DEN_W-1:0] rem_q;

  logic [1:0][DEN_W:0]   rem_sh;
  logic [1:0]            fits;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rem_sh[l] = {rem_q[l], num_q[l][NUM_W-1]};
      fits[l]   = rem_sh[l] >= {1'b0, den_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // numerator register fills up with quotient bits from the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      num_q <= num_i;
      rem_q <= '0;
    end else if (busy_q) begin
      for (int l = 0; l < 2; l++) begin
        if (fits[l]) begin
          rem_q[l] <= DEN_W'(rem_sh[l] - {1'b0, den_q});
        end else begin
          rem_q[l] <= rem_sh[l][DEN_W-1:0];
        end
        num_q[l] <= {num_q[l][NUM_W-2:0], fits[l]};
      end
    end
  end

  assign done_o = busy_q && (cnt_q == CNT_W'(1));
  assign quot_o = num_q;

endmodule

`default_nettype wire

[rtl/core/dual_axis_averaged_command_gate.sv]
// Top level: two-axis moving average with a period-limited change gate.
//
// Usage: each word on scan_i carries an x and y sample and the current tick.
// Both samples go into a ring memory of MAX_WINDOW pairs; running sums and a
// fill count give the averages, sum / count truncated. A command word with
// the two averages goes out on cmd_o when at least min_period ticks have
// passed since the last command and either max_period has been reached or
// one axis has moved by change_tol or more; otherwise the scan yields nothing.
// Flow: a scan is taken only while the block is idle. A scan gated by
// min_period passes through the read state only; any other goes on through
// the divide and check states, the divide being done by the bit-serial
// divider, which produces one quotient bit per cycle for both axes at once.
// A command is loaded into the output register in the check state.
// A stalled receiver holds the command word in the output register; the
// block still takes and processes the next scan and waits only if that scan
// produces another command before the first has left.
// Reset marks every ring entry as unwritten, clears the sums and the last
// command and loads the register defaults. Writing window_len restarts the filter.
`default_nettype none

module dual_axis_averaged_command_gate #(
  parameter int MAX_WINDOW = daacg_pkg::MAX_WINDOW_DEF,
  parameter int ADC_BITS   = daacg_pkg::ADC_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [daacg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [daacg_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  daacg_scan_if.sink                              scan_i,
  daacg_cmd_if.source                             cmd_o
);

  import daacg_pkg::*;

  localparam int SMP_W   = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
  localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
  localparam int RING_AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_W   = SMP_W + WIN_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_CHECK
  } state_e;

  // configuration
  logic [WIN_REG_W-1:0] window_len_q;
  logic [TIME_W-1:0]    min_period_q;
  logic [TIME_W-1:0]    max_period_q;
  logic [TOL_W-1:0]     change_tol_q;

  // filter and gate state
  state_e               state_q;
  logic [SUM_W-1:0]     sum_x_q, sum_y_q;
  logic [WIN_W-1:0]     fill_q;
  logic [RING_AW-1:0]   slot_q;
  logic [MAX_WINDOW-1:0] valid_q;
  logic [TIME_W-1:0]    last_time_q;
  logic [SMP_W-1:0]     last_x_q, last_y_q;

  // current scan
  logic [SMP_W-1:0]     sx_q, sy_q;
  logic [TIME_W-1:0]    now_q;

  // output register
  logic                 cmd_valid_q;
  logic [SAMPLE_W-1:0]  avg_x_q, avg_y_q;

  // ring memory
  logic [2*SMP_W-1:0]   ring_mem [MAX_WINDOW];
  logic [2*SMP_W-1:0]   ring_rdata_q;

  logic                 scan_acc;
  logic [WIN_W-1:0]     win;
  logic [SMP_W-1:0]     old_x, old_y;
  logic [SUM_W-1:0]     sum_x_d, sum_y_d;
  logic [WIN_W-1:0]     fill_d;
  logic [RING_AW-1:0]   slot_d;
  logic [TIME_W-1:0]    delta;
  logic                 pass_min;
  logic                 div_start, div_done;
  logic [1:0][SUM_W-1:0] quot;
  logic [SMP_W-1:0]     ax, ay, dx, dy;
  logic                 emit;
  logic                 cmd_load;

  assign scan_i.ready = (state_q == ST_IDLE);
  assign scan_acc     = scan_i.valid && scan_i.ready;

  assign cmd_o.valid  = cmd_valid_q;
  assign cmd_o.avg_x  = avg_x_q;
  assign cmd_o.avg_y  = avg_y_q;

  always_comb begin
    if (window_len_q == '0) begin
      win = WIN_W'(1);
    end else if (32'(window_len_q) > 32'(MAX_WINDOW)) begin
      win = WIN_W'(MAX_WINDOW);
    end else begin
      win = WIN_W'(window_len_q);
    end
  end

  // an entry never written since the last restart reads as zero
  assign old_x   = valid_q[slot_q] ? ring_rdata_q[SMP_W-1:0] : '0;
  assign old_y   = valid_q[slot_q] ? ring_rdata_q[2*SMP_W-1:SMP_W] : '0;
  assign sum_x_d = sum_x_q - SUM_W'(old_x) + SUM_W'(sx_q);
  assign sum_y_d = sum_y_q - SUM_W'(old_y) + SUM_W'(sy_q);
  assign fill_d  = (fill_q < win) ? fill_q + WIN_W'(1) : win;
  assign slot_d  = ((WIN_W'(slot_q) + WIN_W'(1)) == win) ? '0 : slot_q + RING_AW'(1);

  assign delta     = now_q - last_time_q;
  assign pass_min  = delta >= min_period_q;
  assign div_start = (state_q == ST_READ) && pass_min;

  daacg_div #(
    .NUM_W (SUM_W),
    .DEN_W (WIN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({sum_y_d, sum_x_d}),
    .den_i   (fill_d),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign ax = quot[0][SMP_W-1:0];
  assign ay = quot[1][SMP_W-1:0];
  assign dx = (ax >= last_x_q) ? ax - last_x_q : last_x_q - ax;
  assign dy = (ay >= last_y_q) ? ay - last_y_q : last_y_q - ay;
  assign emit = (delta >= max_period_q) || (TOL_W'(dx) >= change_tol_q) ||
                (TOL_W'(dy) >= change_tol_q);

  // load the output register once it is free or being taken
  assign cmd_load = (state_q == ST_CHECK) && emit && (!cmd_valid_q || cmd_o.ready);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      ring_mem[slot_q] <= {sy_q, sx_q};
    end
    if (scan_acc) begin
      ring_rdata_q <= ring_mem[slot_q];
    end
  end

  // hold the scan while it is processed
  always_ff @(posedge clk_i) begin
    if (scan_acc) begin
      sx_q  <= scan_i.sample_x[SMP_W-1:0];
      sy_q  <= scan_i.sample_y[SMP_W-1:0];
      now_q <= scan_i.time_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      window_len_q <= WINDOW_LEN_RST;
      min_period_q <= MIN_PERIOD_RST;
      max_period_q <= MAX_PERIOD_RST;
      change_tol_q <= CHANGE_TOL_RST;
      sum_x_q      <= '0;
      sum_y_q      <= '0;
      fill_q       <= '0;
      slot_q       <= '0;
      valid_q      <= '0;
      last_time_q  <= '0;
      last_x_q     <= '0;
      last_y_q     <= '0;
      cmd_valid_q  <= 1'b0;
      avg_x_q      <= '0;
      avg_y_q      <= '0;
    end else begin
      if (cmd_load) begin
        cmd_valid_q <= 1'b1;
      end else if (cmd_o.ready) begin
        cmd_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (scan_acc) begin
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          sum_x_q         <= sum_x_d;
          sum_y_q         <= sum_y_d;
          fill_q          <= fill_d;
          slot_q          <= slot_d;
          valid_q[slot_q] <= 1'b1;
          state_q         <= pass_min ? ST_DIV : ST_IDLE;
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (!emit) begin
            state_q <= ST_IDLE;
          end else if (cmd_load) begin
            avg_x_q     <= SAMPLE_W'(ax);
            avg_y_q     <= SAMPLE_W'(ay);
            last_x_q    <= ax;
            last_y_q    <= ay;
            last_time_q <= now_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_WINDOW_LEN: begin
            window_len_q <= cfg_wdata_i[WIN_REG_W-1:0];
            // restart the filter
            sum_x_q      <= '0;
            sum_y_q      <= '0;
            fill_q       <= '0;
            slot_q       <= '0;
            valid_q      <= '0;
          end
          CFG_MIN_PERIOD: min_period_q <= cfg_wdata_i[TIME_W-1:0];
          CFG_MAX_PERIOD: max_period_q <= cfg_wdata_i[TIME_W-1:0];
          CFG_CHANGE_TOL: change_tol_q <= cfg_wdata_i[TOL_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/daacg_checker.sv]
// Port-level assertions for the averaged command gate, bound to the top level.
`default_nettype none

module daacg_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic scan_valid_i,
  input wire logic scan_ready_i,
  input wire logic cmd_valid_i,
  input wire logic cmd_ready_i
);

  logic scan_acc;
  assign scan_acc = scan_valid_i && scan_ready_i;

  // a command word stays until taken
  a_cmd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && !cmd_ready_i |=> cmd_valid_i)
    else $error("command word dropped before it was taken");

  // one scan at a time: ready drops after a word is taken
  a_one_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_acc |=> !scan_ready_i)
    else $error("scan taken while the previous one is in work");

  // a command needs the read and the divide, never the very next cycle
  a_cmd_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(cmd_valid_i) |-> !$past(scan_acc))
    else $error("command appeared one cycle after its scan");

  // no command right out of reset
  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !cmd_valid_i)
    else $error("command valid out of reset");

endmodule

bind dual_axis_averaged_command_gate daacg_checker u_daacg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .scan_valid_i (scan_i.valid),
  .scan_ready_i (scan_i.ready),
  .cmd_valid_i  (cmd_o.valid),
  .cmd_ready_i  (cmd_o.ready)
);

`default_nettype wire
